// ===== rtl/core/shabh_pkg.sv =====
package shabh_pkg;

  // Input request: one message word and its framing marks
  typedef struct packed {
    logic [31:0] msg_word;
    logic        first_of_message;
    logic        last_of_message;
  } in_req_t;

  // Output response: one digest word with its index and last mark
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_rsp_t;

  // Round variables a..h
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_vars_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constant lookup
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/shabh_round.sv =====
module shabh_round
  import shabh_pkg::*;
(
  input  work_vars_t  vars_i,
  input  logic [5:0]  rnd_i,
  input  logic [31:0] w0_i,
  input  logic [31:0] w1_i,
  input  logic [31:0] w9_i,
  input  logic [31:0] w14_i,
  output work_vars_t  vars_o,
  output logic [31:0] w_new_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1;

  // Compress one round
  always_comb begin
    big1 = rotr(vars_i.e, 6) ^ rotr(vars_i.e, 11) ^ rotr(vars_i.e, 25);
    ch   = (vars_i.e & vars_i.f) ^ (~vars_i.e & vars_i.g);
    big0 = rotr(vars_i.a, 2) ^ rotr(vars_i.a, 13) ^ rotr(vars_i.a, 22);
    maj  = (vars_i.a & vars_i.b) ^ (vars_i.a & vars_i.c) ^ (vars_i.b & vars_i.c);
    t1   = vars_i.h + big1 + ch + round_k(rnd_i) + w0_i;
    t2   = big0 + maj;
    vars_o.h = vars_i.g;
    vars_o.g = vars_i.f;
    vars_o.f = vars_i.e;
    vars_o.e = vars_i.d + t1;
    vars_o.d = vars_i.c;
    vars_o.c = vars_i.b;
    vars_o.b = vars_i.a;
    vars_o.a = t1 + t2;
  end

  // Expand the next schedule word
  always_comb begin
    s0 = rotr(w1_i, 7) ^ rotr(w1_i, 18) ^ (w1_i >> 3);
    s1 = rotr(w14_i, 17) ^ rotr(w14_i, 19) ^ (w14_i >> 10);
    w_new_o = s1 + w9_i + s0 + w0_i;
  end

endmodule

// ===== rtl/core/sha256_block_hash.sv =====
// A word that neither completes a block nor carries the last mark is taken; busy stays low.
// The sixteenth word of a block holds busy for 64 rounds on one shared round unit,
// then for the fold into the chaining hash.
// A word marked last also adds the eight digest words, one digest word per cycle; the receiver cannot stall.
// No new word is taken while busy, so the single round unit sets the pace of blocks.
// Reset (rst_n low, synchronous) loads the initial hash and clears the word count.
module sha256_block_hash
  import shabh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_valid,
  output out_rsp_t out_data
);

  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        last_pend_r, last_pend_nxt;
  logic [31:0] chain_r [HASH_WORDS];
  logic [31:0] chain_nxt [HASH_WORDS];
  logic [31:0] w_r [BLOCK_WORDS];
  logic [31:0] w_nxt [BLOCK_WORDS];
  work_vars_t  vars_r, vars_nxt;
  work_vars_t  vars_rnd;
  logic [31:0] w_new;
  logic [3:0]  cnt_base;
  logic        accept;

  shabh_round u_round (
    .vars_i  (vars_r),
    .rnd_i   (rnd_r),
    .w0_i    (w_r[0]),
    .w1_i    (w_r[1]),
    .w9_i    (w_r[9]),
    .w14_i   (w_r[14]),
    .vars_o  (vars_rnd),
    .w_new_o (w_new)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Sequence requests, rounds, hash update and digest output
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    last_pend_nxt = last_pend_r;
    chain_nxt     = chain_r;
    w_nxt         = w_r;
    vars_nxt      = vars_r;
    cnt_base      = in_data.first_of_message ? 4'd0 : cnt_r;
    out_valid     = 1'b0;
    out_data.digest_word  = chain_r[idx_r];
    out_data.digest_index = idx_r;
    out_data.digest_last  = (idx_r == 3'(HASH_WORDS - 1));

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.first_of_message) begin
            chain_nxt = INIT_HASH;
          end
          for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            w_nxt[i] = w_r[i + 1];
          end
          w_nxt[BLOCK_WORDS - 1] = in_data.msg_word;
          if (cnt_base == 4'(BLOCK_WORDS - 1)) begin
            // Block full: load round variables from the chaining hash
            cnt_nxt       = 4'd0;
            rnd_nxt       = 6'd0;
            last_pend_nxt = in_data.last_of_message;
            vars_nxt      = {chain_r[0], chain_r[1], chain_r[2], chain_r[3],
                             chain_r[4], chain_r[5], chain_r[6], chain_r[7]};
            state_nxt     = ST_ROUND;
          end else if (in_data.last_of_message) begin
            // Drop the partial block and emit the digest as it stands
            cnt_nxt   = 4'd0;
            idx_nxt   = 3'd0;
            state_nxt = ST_OUT;
          end else begin
            cnt_nxt = cnt_base + 4'd1;
          end
        end
      end
      ST_ROUND: begin
        vars_nxt = vars_rnd;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[BLOCK_WORDS - 1] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + vars_r.a;
        chain_nxt[1] = chain_r[1] + vars_r.b;
        chain_nxt[2] = chain_r[2] + vars_r.c;
        chain_nxt[3] = chain_r[3] + vars_r.d;
        chain_nxt[4] = chain_r[4] + vars_r.e;
        chain_nxt[5] = chain_r[5] + vars_r.f;
        chain_nxt[6] = chain_r[6] + vars_r.g;
        chain_nxt[7] = chain_r[7] + vars_r.h;
        idx_nxt      = 3'd0;
        state_nxt    = last_pend_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        idx_nxt   = idx_r + 3'd1;
        if (idx_r == 3'(HASH_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state and the chaining hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 4'd0;
      rnd_r       <= 6'd0;
      idx_r       <= 3'd0;
      last_pend_r <= 1'b0;
      chain_r     <= INIT_HASH;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      last_pend_r <= last_pend_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // Advance the schedule window and round variables
  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    vars_r <= vars_nxt;
  end

endmodule

// ===== rtl/core/shabh_check.sv =====
module shabh_check
  import shabh_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_req_t  in_data,
  input logic     out_valid,
  input out_rsp_t out_data
);

  // Output words appear only while the block refuses requests
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("digest word shown while idle");

  // Digest words come in index order with no gaps
  a_out_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.digest_last) |=>
      (out_valid && out_data.digest_index == $past(out_data.digest_index) + 3'd1))
    else $error("digest word sequence broken");

  // Last mark only on index seven
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.digest_last) |-> (out_data.digest_index == 3'd7))
    else $error("last mark on wrong index");

  // A request without the last mark makes no output next cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.last_of_message) |=> !out_valid)
    else $error("digest word without a last request");

  // A digest run ends after its last word
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.digest_last) |=> !out_valid)
    else $error("output continues past the last word");

endmodule

bind sha256_block_hash shabh_check u_shabh_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import shabh_pkg::*;
();

  // Standard SHA-256 starting hash and round constants, kept locally for the predictor
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Digests that can be read off directly
  localparam logic [255:0] IV_DIGEST =
    256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;
  localparam logic [255:0] EMPTY_MSG_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;

  typedef enum int {
    MSG_FRAMED,
    MSG_PARTIAL,
    MSG_UNFRAMED,
    MSG_NOISE
  } msg_kind_t;

  typedef struct packed {
    in_req_t      req;
    logic         use_lit;
    logic [255:0] lit;
  } stim_row_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_data = '0;
  logic     out_valid;
  out_rsp_t out_data;

  // Predictor state
  logic [31:0] hash_state [8] = SHA_IV;
  logic [31:0] block_words [16];
  int unsigned block_fill = 0;

  out_rsp_t    digest_due [$];
  stim_row_t   directed_rows [$];
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned digests_seen = 0;
  int unsigned messages_done = 0;

  sha256_block_hash u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Expand the schedule and fold 64 rounds into the hash state
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = block_words[t];
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  // Absorb one accepted request; return 1 when it releases a digest
  function automatic bit absorb_word(input in_req_t req);
    if (req.first_of_message) begin
      hash_state = SHA_IV;
      block_fill = 0;
    end
    block_words[block_fill[3:0]] = req.msg_word;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
    if (req.last_of_message) block_fill = 0;
    return req.last_of_message;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Present a request and hold it until the block takes it
  task automatic send_req(input in_req_t req, input bit use_lit, input logic [255:0] lit);
    out_rsp_t r;
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (absorb_word(req)) begin
      messages_done++;
      for (int i = 0; i < 8; i++) begin
        r.digest_word  = use_lit ? lit[255 - 32*i -: 32] : hash_state[i];
        r.digest_index = i[2:0];
        r.digest_last  = (i == 7);
        digest_due.push_back(r);
      end
    end
  endtask

  // Drop start for a random gap now and then, except in the quiet stretch
  task automatic pace_sender();
    int unsigned gap;
    if (words_sent >= 60 && words_sent < 100) return;
    if ($urandom_range(0, 99) >= 24) return;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 4);
    start   <= 1'b0;
    in_data <= {$urandom, 2'($urandom)};
    repeat (gap) @(posedge clk);
  endtask

  // Hold the sender off until every pending digest word has come back
  task automatic drain_digests();
    start <= 1'b0;
    @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
  endtask

  // Send one message of n words; first mark optional, last mark on the final word
  task automatic send_message(input int unsigned n, input bit with_first);
    in_req_t req;
    for (int unsigned i = 0; i < n; i++) begin
      req.msg_word         = rand_word();
      req.first_of_message = with_first && (i == 0);
      req.last_of_message  = (i == n - 1);
      send_req(req, 1'b0, '0);
      pace_sender();
    end
  endtask

  function automatic void add_row(input logic [31:0] w, input bit first, input bit last,
                                  input bit use_lit, input logic [255:0] lit);
    stim_row_t row;
    row.req.msg_word         = w;
    row.req.first_of_message = first;
    row.req.last_of_message  = last;
    row.use_lit              = use_lit;
    row.lit                  = lit;
    directed_rows.push_back(row);
  endfunction

  // Compare each digest word with the oldest pending one
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid) begin
      digests_seen++;
      if (digest_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected digest word %h idx %0d last %0b",
                   out_data.digest_word, out_data.digest_index, out_data.digest_last);
      end else begin
        want = digest_due.pop_front();
        if (want.digest_word !== out_data.digest_word ||
            want.digest_index !== out_data.digest_index ||
            want.digest_last !== out_data.digest_last) begin
          err_count++;
          if (err_count <= 10)
            $display("digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                     want.digest_word, want.digest_index, want.digest_last,
                     out_data.digest_word, out_data.digest_index, out_data.digest_last);
        end
      end
    end
  end

  initial begin
    int unsigned random_words;
    int unsigned n_directed;
    bit          paused;
    msg_kind_t   kind;
    in_req_t     req;

    // Directed table: unframed partial, first and last together, empty message,
    // chained digest without a first mark, partial after a first mark
    add_row(32'hffff_ffff, 1'b0, 1'b1, 1'b1, IV_DIGEST);
    add_row(32'h0000_0000, 1'b1, 1'b1, 1'b1, IV_DIGEST);
    add_row(32'h8000_0000, 1'b1, 1'b0, 1'b0, '0);
    for (int i = 0; i < 14; i++) add_row(32'h0000_0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(32'h0000_0000, 1'b0, 1'b1, 1'b1, EMPTY_MSG_DIGEST);
    add_row(32'ha5a5_a5a5, 1'b0, 1'b1, 1'b0, '0);
    add_row(32'hdead_beef, 1'b1, 1'b0, 1'b0, '0);
    add_row(32'h1234_5678, 1'b0, 1'b1, 1'b1, IV_DIGEST);
    n_directed = directed_rows.size();

    // Hold reset, then release
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].req, directed_rows[i].use_lit, directed_rows[i].lit);
      pace_sender();
    end
    drain_digests();

    // Random messages, mostly well framed
    random_words = 0;
    paused = 1'b0;
    while (random_words < 90) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kind = MSG_FRAMED;
        6, 7: kind = MSG_PARTIAL;
        8: kind = MSG_UNFRAMED;
        default: kind = MSG_NOISE;
      endcase
      case (kind)
        MSG_FRAMED: begin
          req.msg_word = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(1, 2);
          send_message(16 * req.msg_word, 1'b1);
          random_words += 16 * req.msg_word;
        end
        MSG_PARTIAL: begin
          req.msg_word = $urandom_range(1, 15);
          send_message(req.msg_word, 1'($urandom_range(0, 1)));
          random_words += req.msg_word;
        end
        MSG_UNFRAMED: begin
          send_message(16, 1'b0);
          random_words += 16;
        end
        default: begin
          req.msg_word         = rand_word();
          req.first_of_message = 1'($urandom_range(0, 1));
          req.last_of_message  = 1'($urandom_range(0, 1));
          send_req(req, 1'b0, '0);
          pace_sender();
          random_words++;
        end
      endcase
      if (!paused && random_words >= 50) begin
        drain_digests();
        paused = 1'b1;
      end
    end

    // Drain, then let the block settle
    drain_digests();
    repeat (100) @(posedge clk);

    $display("sent %0d message words (%0d directed), %0d messages closed, %0d digest words",
             words_sent, n_directed, messages_done, digests_seen);
    $display("mix: framed, partial, unframed and noise requests with random gaps");
    if (err_count == 0 && digest_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
